// File: rtl/hkm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared codes and helpers for the host key line matcher.
// ----------------------------------------------------------------------------
package hkm_pkg;

    // request codes
    localparam logic [1:0] REQ_DATA   = 2'd0;
    localparam logic [1:0] REQ_END    = 2'd1;
    localparam logic [1:0] REQ_FAIL   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // verdict codes
    localparam logic [1:0] VERDICT_ABSENT     = 2'd0;
    localparam logic [1:0] VERDICT_MATCH      = 2'd1;
    localparam logic [1:0] VERDICT_MISMATCH   = 2'd2;
    localparam logic [1:0] VERDICT_UNREADABLE = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_NAME_WORD0 = 3'd0;
    localparam logic [2:0] CFG_NAME_WORD1 = 3'd1;
    localparam logic [2:0] CFG_NAME_WORD2 = 3'd2;
    localparam logic [2:0] CFG_NAME_LEN   = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD0  = 3'd4;
    localparam logic [2:0] CFG_KEY_WORD1  = 3'd5;
    localparam logic [2:0] CFG_KEY_WORD2  = 3'd6;
    localparam logic [2:0] CFG_KEY_WORD3  = 3'd7;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    localparam int        NAME_BYTES = 24;
    localparam logic [6:0] KEY_CHARS = 7'd64;
    localparam logic [6:0] KEY_OVER  = 7'd65;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_nibble;

    function automatic t_nibble hex_nibble(input logic [7:0] b);
        t_nibble n;
        n.ok  = 1'b1;
        n.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            n.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            n.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            n.val = 4'(b - 8'h37);
        end else begin
            n.ok = 1'b0;
        end
        return n;
    endfunction

endpackage

// File: rtl/host_key_line_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_key_line_matcher
// Scans newline-separated lines for the configured host name and checks the
// hex key that follows it against the configured 32-byte key.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------
//  in       | in        | i_in_valid / o_in_stall    | i_req_type, i_data_byte
//  out      | out       | o_out_valid / i_out_stall  | o_verdict
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one item per cycle unless o_in_stall; each byte is judged in the accept cycle
//  and any verdict is registered, in the skid entry if the output is stalled.
//  an output register plus one skid entry decouple the sides; o_in_stall rises
//  only while both hold a verdict.
//  synchronous active-low reset clears line state, valid flags and config, not the verdicts.
//  cfg is always ready, one register write per cycle.
// ----------------------------------------------------------------------------
module host_key_line_matcher #(
    parameter int LINE_MAX = 256,
    parameter int NAME_MAX = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_verdict,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int              PosW     = $clog2(LINE_MAX + 2);
    localparam logic [PosW-1:0] PosMax   = PosW'(LINE_MAX);
    localparam logic [PosW-1:0] PosOver  = PosW'(LINE_MAX + 1);
    localparam logic [PosW-1:0] PosNameM = PosW'(NAME_MAX);
    localparam logic [PosW-1:0] PosBytes = PosW'(hkm_pkg::NAME_BYTES);
    localparam logic [4:0]      LenMax   = 5'(NAME_MAX);

    // configuration
    logic [191:0] r_name;
    logic [4:0]   r_name_len;
    logic [255:0] r_key;

    // line state
    logic [PosW-1:0] r_pos, n_pos;
    logic            r_name_eq, n_name_eq;
    logic            r_space, n_space;
    logic [6:0]      r_kcc, n_kcc;
    logic            r_key_eq, n_key_eq;
    logic [3:0]      r_high, n_high;
    logic            r_given, n_given;

    // output register and skid entry
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_verdict, n_out_verdict;
    logic       r_skid_valid, n_skid_valid;
    logic [1:0] r_skid_verdict, n_skid_verdict;

    logic             in_accept;
    logic             res_valid;
    logic [1:0]       res_verdict;
    logic [1:0]       judge;
    logic             names_host;
    logic [4:0]       name_idx;
    logic [7:0]       name_byte;
    logic [7:0]       key_byte;
    hkm_pkg::t_nibble nib;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;
    assign o_cfg_ready = 1'b1;

    assign name_idx  = (r_pos < PosBytes) ? r_pos[4:0] : 5'd0;
    assign name_byte = r_name[name_idx*8 +: 8];
    assign key_byte  = r_key[r_kcc[5:1]*8 +: 8];
    assign nib       = hkm_pkg::hex_nibble(i_data_byte);

    // verdict of the line held so far, if it names the host
    always_comb begin
        names_host = (r_pos <= PosMax) && r_space && r_name_eq;
        judge      = (r_kcc == hkm_pkg::KEY_CHARS && r_key_eq) ?
                     hkm_pkg::VERDICT_MATCH : hkm_pkg::VERDICT_MISMATCH;
    end

    always_comb begin
        n_pos       = r_pos;
        n_name_eq   = r_name_eq;
        n_space     = r_space;
        n_kcc       = r_kcc;
        n_key_eq    = r_key_eq;
        n_high      = r_high;
        n_given     = r_given;
        res_valid   = 1'b0;
        res_verdict = hkm_pkg::VERDICT_ABSENT;

        if (in_accept) begin
            unique case (i_req_type)
                hkm_pkg::REQ_DATA: begin
                    if (!r_given) begin
                        if (i_data_byte == hkm_pkg::CH_NEWLINE) begin
                            n_pos     = '0;
                            n_name_eq = 1'b1;
                            n_space   = 1'b0;
                            n_kcc     = '0;
                            n_key_eq  = 1'b1;
                            n_high    = '0;
                            if (names_host) begin
                                n_given     = 1'b1;
                                res_valid   = 1'b1;
                                res_verdict = judge;
                            end
                        end else if (r_pos >= PosMax) begin
                            n_pos = PosOver;
                        end else begin
                            n_pos = r_pos + 1'b1;
                            if (!r_space) begin
                                if (i_data_byte == hkm_pkg::CH_SPACE) begin
                                    n_space = 1'b1;
                                    if (r_pos != PosW'(r_name_len) || r_name_len > LenMax) begin
                                        n_name_eq = 1'b0;
                                    end
                                end else if (r_pos >= PosW'(r_name_len) || r_pos >= PosNameM ||
                                             r_pos >= PosBytes) begin
                                    n_name_eq = 1'b0;
                                end else if (name_byte != i_data_byte) begin
                                    n_name_eq = 1'b0;
                                end
                            end else if (r_kcc < hkm_pkg::KEY_CHARS) begin
                                if (!nib.ok) begin
                                    n_key_eq = 1'b0;
                                end else if (!r_kcc[0]) begin
                                    n_high = nib.val;
                                end else if ({r_high, nib.val} != key_byte) begin
                                    n_key_eq = 1'b0;
                                end
                                n_kcc = r_kcc + 1'b1;
                            end else begin
                                n_kcc = hkm_pkg::KEY_OVER;
                            end
                        end
                    end
                end
                hkm_pkg::REQ_END, hkm_pkg::REQ_FAIL: begin
                    if (!r_given) begin
                        res_valid = 1'b1;
                        if (i_req_type == hkm_pkg::REQ_FAIL) begin
                            res_verdict = hkm_pkg::VERDICT_UNREADABLE;
                        end else if (r_pos != '0 && names_host) begin
                            res_verdict = judge;
                        end
                    end
                    n_pos     = '0;
                    n_name_eq = 1'b1;
                    n_space   = 1'b0;
                    n_kcc     = '0;
                    n_key_eq  = 1'b1;
                    n_high    = '0;
                    n_given   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register with skid entry
    always_comb begin
        n_out_valid    = r_out_valid;
        n_out_verdict  = r_out_verdict;
        n_skid_valid   = r_skid_valid;
        n_skid_verdict = r_skid_verdict;
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                n_out_valid   = 1'b1;
                n_out_verdict = r_skid_verdict;
                n_skid_valid  = 1'b0;
            end else begin
                n_out_valid   = res_valid;
                n_out_verdict = res_verdict;
            end
        end else if (res_valid) begin
            n_skid_valid   = 1'b1;
            n_skid_verdict = res_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_name_eq    <= 1'b1;
            r_space      <= 1'b0;
            r_kcc        <= '0;
            r_key_eq     <= 1'b1;
            r_high       <= '0;
            r_given      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_name       <= '0;
            r_name_len   <= '0;
            r_key        <= '0;
        end else begin
            r_pos        <= n_pos;
            r_name_eq    <= n_name_eq;
            r_space      <= n_space;
            r_kcc        <= n_kcc;
            r_key_eq     <= n_key_eq;
            r_high       <= n_high;
            r_given      <= n_given;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    hkm_pkg::CFG_NAME_WORD0: r_name[63:0]    <= i_cfg_data;
                    hkm_pkg::CFG_NAME_WORD1: r_name[127:64]  <= i_cfg_data;
                    hkm_pkg::CFG_NAME_WORD2: r_name[191:128] <= i_cfg_data;
                    hkm_pkg::CFG_NAME_LEN:   r_name_len      <= i_cfg_data[4:0];
                    hkm_pkg::CFG_KEY_WORD0:  r_key[63:0]     <= i_cfg_data;
                    hkm_pkg::CFG_KEY_WORD1:  r_key[127:64]   <= i_cfg_data;
                    hkm_pkg::CFG_KEY_WORD2:  r_key[191:128]  <= i_cfg_data;
                    hkm_pkg::CFG_KEY_WORD3:  r_key[255:192]  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_verdict  <= n_out_verdict;
        r_skid_verdict <= n_skid_verdict;
    end

endmodule

// File: rtl/hkm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkm_checker
// Port-level checks for the host key line matcher, bound to the top level.
// ----------------------------------------------------------------------------
module hkm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_req_type,
    input logic [7:0] i_data_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_verdict
);

    logic in_accept;
    logic quiet_item;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign quiet_item = (i_req_type == hkm_pkg::REQ_UNUSED) ||
                        (i_req_type == hkm_pkg::REQ_DATA &&
                         i_data_byte != hkm_pkg::CH_NEWLINE);

    // a pending transaction is held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_verdict_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_verdict))
        else $error("verdict changed while stalled");

    // reset leaves no result behind
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall present after reset");

    // input side only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // a plain byte or unknown request never produces a verdict
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && quiet_item && !o_out_valid |=> !o_out_valid)
        else $error("verdict from a byte that ends no line");

endmodule

bind host_key_line_matcher hkm_checker u_hkm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_req_type  (i_req_type),
    .i_data_byte (i_data_byte),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_verdict   (o_verdict)
);
